>>> rtl/bzs_pkg.sv
`timescale 1ns / 1ps
package bzs_pkg;

   // Q1.16 parameter, 65536 = 1.0
   localparam int TW = 17;
   localparam logic [TW-1:0] T_ONE = 17'd65536;

   // control coordinate width, signed Q15.16
   localparam int CW = 32;

   // weight width, units of 2^-48, at most 2^48
   localparam int WW = 49;
   localparam int WSPLIT = 24;

   // register map
   localparam int NUM_REGS = 8;
   localparam logic [2:0] REG_CTRL0_X = 3'd0;
   localparam logic [2:0] REG_CTRL0_Y = 3'd1;
   localparam logic [2:0] REG_CTRL1_X = 3'd2;
   localparam logic [2:0] REG_CTRL1_Y = 3'd3;
   localparam logic [2:0] REG_CTRL2_X = 3'd4;
   localparam logic [2:0] REG_CTRL2_Y = 3'd5;
   localparam logic [2:0] REG_CTRL3_X = 3'd6;
   localparam logic [2:0] REG_CTRL3_Y = 3'd7;

   // four control coordinates of one axis
   typedef logic [3:0][CW-1:0] ctrl_vec_type;

   // one curve parameter travelling down the evaluation pipeline
   typedef struct packed {
      logic          valid;
      logic [TW-1:0] t;
      logic [5:0]    index;
      logic          last;
   } pt_type;

endpackage

>>> rtl/bzs_div.sv
`timescale 1ns / 1ps
module bzs_div #(
   parameter int DW = 7
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  go,
   input  logic [bzs_pkg::TW-1:0] dividend,
   input  logic [DW-1:0]         divisor,
   output logic                  done,
   output logic [bzs_pkg::TW-1:0] quot,
   output logic [DW-1:0]         rem
);

   localparam int CNTW = $clog2(bzs_pkg::TW + 1);

   logic                   run_ff, run_in;
   logic                   done_ff, done_in;
   logic [CNTW-1:0]        cnt_ff, cnt_in;
   logic [bzs_pkg::TW-1:0] quo_ff, quo_in;
   logic [DW-1:0]          rem_ff, rem_in;
   logic [DW-1:0]          dvs_ff, dvs_in;
   logic [DW:0]            rem_sh;
   logic                   fits;

   // one quotient bit a cycle, restoring
   always_comb begin
      rem_sh = {rem_ff, quo_ff[bzs_pkg::TW-1]};
      fits = rem_sh >= {1'b0, dvs_ff};
      run_in = run_ff;
      done_in = 1'b0;
      cnt_in = cnt_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      dvs_in = dvs_ff;
      if (go) begin
         run_in = 1'b1;
         cnt_in = '0;
         quo_in = dividend;
         rem_in = '0;
         dvs_in = divisor;
      end else if (run_ff) begin
         quo_in = {quo_ff[bzs_pkg::TW-2:0], fits};
         rem_in = fits ? DW'(rem_sh - {1'b0, dvs_ff}) : rem_sh[DW-1:0];
         cnt_in = CNTW'(cnt_ff + 1'b1);
         if (cnt_ff == CNTW'(bzs_pkg::TW - 1)) begin
            run_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         run_ff <= run_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done = done_ff;
   assign quot = quo_ff;
   assign rem = rem_ff;

endmodule

>>> rtl/bzs_seq.sv
`timescale 1ns / 1ps
module bzs_seq #(
   parameter int MAX_POINTS = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [bzs_pkg::TW-1:0] t_start,
   input  logic [bzs_pkg::TW-1:0] t_end,
   input  logic [6:0]             point_count,
   output logic                   busy,
   output bzs_pkg::pt_type        pt
);

   localparam int IW = $clog2(MAX_POINTS + 1);
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_RUN  = 2'd2;

   logic [1:0]             state_ff, state_in;
   logic [bzs_pkg::TW-1:0] ts_ff, ts_in;
   logic                   neg_ff, neg_in;
   logic [IW-1:0]          den_ff, den_in;
   logic [IW-1:0]          idx_ff, idx_in;
   logic [bzs_pkg::TW-1:0] q_ff, q_in;
   logic [IW-1:0]          r_ff, r_in;
   logic [bzs_pkg::TW-1:0] stp_q_ff, stp_q_in;
   logic [IW-1:0]          stp_r_ff, stp_r_in;

   logic                   accept;
   logic [bzs_pkg::TW-1:0] ts_sat, te_sat, mag;
   logic [IW-1:0]          n_sat;
   logic                   div_go, div_done;
   logic [bzs_pkg::TW-1:0] div_quot;
   logic [IW-1:0]          div_rem;
   logic [IW:0]            r_sum;
   logic                   is_last;
   logic [31:0]            idx_wide;

   assign accept = start && (state_ff == ST_IDLE);
   assign busy = state_ff != ST_IDLE;

   // clamp the request fields
   always_comb begin
      ts_sat = (t_start > bzs_pkg::T_ONE) ? bzs_pkg::T_ONE : t_start;
      te_sat = (t_end > bzs_pkg::T_ONE) ? bzs_pkg::T_ONE : t_end;
      if (32'(point_count) > 32'(MAX_POINTS)) begin
         n_sat = IW'(MAX_POINTS);
      end else begin
         n_sat = IW'(point_count);
      end
      mag = (te_sat >= ts_sat) ? bzs_pkg::TW'(te_sat - ts_sat)
                               : bzs_pkg::TW'(ts_sat - te_sat);
   end

   assign div_go = accept && (n_sat > IW'(1));

   // split |d| into whole steps and a remainder per point
   bzs_div #(.DW(IW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .go       (div_go),
      .dividend (mag),
      .divisor  (IW'(n_sat - 1'b1)),
      .done     (div_done),
      .quot     (div_quot),
      .rem      (div_rem)
   );

   assign is_last = idx_ff == den_ff;
   assign r_sum = {1'b0, r_ff} + {1'b0, stp_r_ff};
   assign idx_wide = 32'(idx_ff);

   // sequence the points of a request
   always_comb begin
      state_in = state_ff;
      ts_in = ts_ff;
      neg_in = neg_ff;
      den_in = den_ff;
      idx_in = idx_ff;
      q_in = q_ff;
      r_in = r_ff;
      stp_q_in = stp_q_ff;
      stp_r_in = stp_r_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && (n_sat != '0)) begin
               ts_in = ts_sat;
               neg_in = te_sat < ts_sat;
               den_in = IW'(n_sat - 1'b1);
               idx_in = '0;
               q_in = '0;
               r_in = '0;
               stp_q_in = '0;
               stp_r_in = '0;
               state_in = (n_sat == IW'(1)) ? ST_RUN : ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               stp_q_in = div_quot;
               stp_r_in = div_rem;
               r_in = den_ff >> 1;
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (is_last) begin
               state_in = ST_IDLE;
            end else begin
               idx_in = IW'(idx_ff + 1'b1);
               if (r_sum >= {1'b0, den_ff}) begin
                  r_in = IW'(r_sum - {1'b0, den_ff});
                  q_in = bzs_pkg::TW'(q_ff + stp_q_ff + 1'b1);
               end else begin
                  r_in = r_sum[IW-1:0];
                  q_in = bzs_pkg::TW'(q_ff + stp_q_ff);
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      pt.valid = state_ff == ST_RUN;
      pt.t = neg_ff ? bzs_pkg::TW'(ts_ff - q_ff) : bzs_pkg::TW'(ts_ff + q_ff);
      pt.index = idx_wide[5:0];
      pt.last = is_last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      ts_ff <= ts_in;
      neg_ff <= neg_in;
      den_ff <= den_in;
      idx_ff <= idx_in;
      q_ff <= q_in;
      r_ff <= r_in;
      stp_q_ff <= stp_q_in;
      stp_r_ff <= stp_r_in;
   end

endmodule

>>> rtl/bzs_eval.sv
`timescale 1ns / 1ps
module bzs_eval (
   input  logic                  clock,
   input  logic                  reset,
   input  bzs_pkg::pt_type       pt,
   input  bzs_pkg::ctrl_vec_type px,
   input  bzs_pkg::ctrl_vec_type py,
   output logic                  out_valid,
   output logic [31:0]           out_x,
   output logic [31:0]           out_y,
   output logic [5:0]            out_index,
   output logic                  out_last
);

   localparam int HW = bzs_pkg::WW - bzs_pkg::WSPLIT;
   localparam int PW = bzs_pkg::CW + HW + 1;
   localparam int SW = PW + 2;

   bzs_pkg::pt_type pt1_ff, pt2_ff, pt3_ff, pt4_ff;

   // stage 1: squares and cross term
   logic [bzs_pkg::TW-1:0]   s_in, t1_ff, s1_ff;
   logic [2*bzs_pkg::TW-1:0] ss_ff, st_ff, tt_ff;
   // stage 2: Bernstein weights
   logic [3:0][bzs_pkg::WW-1:0] w_ff, w_in;
   // stage 3: partial products
   logic signed [PW-1:0] hx_ff [4], lx_ff [4], hy_ff [4], ly_ff [4];
   // stage 4: sums
   logic signed [SW-1:0] shx_ff, slx_ff, shy_ff, sly_ff;
   // stage 5: round and saturate
   logic signed [SW:0]   totx, toty;

   assign s_in = bzs_pkg::TW'(bzs_pkg::T_ONE - pt.t);

   always_comb begin
      w_in[0] = bzs_pkg::WW'(ss_ff * s1_ff);
      w_in[1] = bzs_pkg::WW'(3 * (ss_ff * t1_ff));
      w_in[2] = bzs_pkg::WW'(3 * (st_ff * t1_ff));
      w_in[3] = bzs_pkg::WW'(tt_ff * t1_ff);
   end

   function automatic logic [31:0] round_sat(input logic signed [SW:0] v);
      logic signed [SW-bzs_pkg::WSPLIT:0] r;
      r = v[SW:bzs_pkg::WSPLIT];
      if (r > $signed((SW-bzs_pkg::WSPLIT+1)'(32'sh7fffffff))) begin
         round_sat = 32'h7fffffff;
      end else if (r < -$signed((SW-bzs_pkg::WSPLIT+1)'(33'sh080000000))) begin
         round_sat = 32'h80000000;
      end else begin
         round_sat = r[31:0];
      end
   endfunction

   // split weights and form all products of one point
   always_ff @(posedge clock) begin
      for (int k = 0; k < 4; k++) begin
         hx_ff[k] <= $signed(px[k]) * $signed({1'b0, w_ff[k][bzs_pkg::WW-1:bzs_pkg::WSPLIT]});
         lx_ff[k] <= $signed(px[k]) * $signed({1'b0, w_ff[k][bzs_pkg::WSPLIT-1:0]});
         hy_ff[k] <= $signed(py[k]) * $signed({1'b0, w_ff[k][bzs_pkg::WW-1:bzs_pkg::WSPLIT]});
         ly_ff[k] <= $signed(py[k]) * $signed({1'b0, w_ff[k][bzs_pkg::WSPLIT-1:0]});
      end
   end

   // carry the parameter forward and register the squares, weights, sums and rounded results, stage by stage
   always_ff @(posedge clock) begin
      t1_ff <= pt.t;
      s1_ff <= s_in;
      ss_ff <= s_in * s_in;
      st_ff <= s_in * pt.t;
      tt_ff <= pt.t * pt.t;
      w_ff <= w_in;
      shx_ff <= SW'(hx_ff[0]) + SW'(hx_ff[1]) + SW'(hx_ff[2]) + SW'(hx_ff[3]);
      slx_ff <= SW'(lx_ff[0]) + SW'(lx_ff[1]) + SW'(lx_ff[2]) + SW'(lx_ff[3]);
      shy_ff <= SW'(hy_ff[0]) + SW'(hy_ff[1]) + SW'(hy_ff[2]) + SW'(hy_ff[3]);
      sly_ff <= SW'(ly_ff[0]) + SW'(ly_ff[1]) + SW'(ly_ff[2]) + SW'(ly_ff[3]);
      out_x <= round_sat(totx);
      out_y <= round_sat(toty);
      out_index <= pt4_ff.index;
      out_last <= pt4_ff.last;
   end

   // fold low part in, add one half, floor
   assign totx = (SW+1)'(shx_ff) + (SW+1)'(slx_ff >>> bzs_pkg::WSPLIT)
               + (SW+1)'(1 << (bzs_pkg::WSPLIT - 1));
   assign toty = (SW+1)'(shy_ff) + (SW+1)'(sly_ff >>> bzs_pkg::WSPLIT)
               + (SW+1)'(1 << (bzs_pkg::WSPLIT - 1));

   // valid bits travel with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         pt1_ff <= '0;
         pt2_ff <= '0;
         pt3_ff <= '0;
         pt4_ff <= '0;
         out_valid <= 1'b0;
      end else begin
         pt1_ff <= pt;
         pt2_ff <= pt1_ff;
         pt3_ff <= pt2_ff;
         pt4_ff <= pt3_ff;
         out_valid <= pt4_ff.valid;
      end
   end

endmodule

>>> rtl/cubic_bezier_point_sampler_top.sv
`timescale 1ns / 1ps
// A one-point request skips the division; longer requests first wait for the serial
// 17-bit step divider. Points then leave one per cycle through the evaluation pipeline.
// busy holds off a new request until the sequencer has issued the last point of the current one.
// Reset clears the sequencer, pipeline valids and control points to zero.
// Results are strobed for one cycle; the receiver cannot stall them.
module cubic_bezier_point_sampler_top #(
   parameter int MAX_POINTS = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [16:0] req_t_start,
   input  logic [16:0] req_t_end,
   input  logic [6:0]  req_point_count,
   output logic        rsp_valid,
   output logic [31:0] rsp_point_x,
   output logic [31:0] rsp_point_y,
   output logic [5:0]  rsp_point_index,
   output logic        rsp_last,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [4:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   logic [31:0] ctrl_ff [bzs_pkg::NUM_REGS];
   logic [2:0]  reg_idx;
   bzs_pkg::ctrl_vec_type px, py;
   bzs_pkg::pt_type pt;

   assign reg_idx = paddr[4:2];
   assign pready = 1'b1;
   assign prdata = ctrl_ff[reg_idx];

   // write control points
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < bzs_pkg::NUM_REGS; k++) begin
            ctrl_ff[k] <= '0;
         end
      end else if (psel && penable && pwrite) begin
         ctrl_ff[reg_idx] <= pwdata;
      end
   end

   always_comb begin
      px[0] = ctrl_ff[bzs_pkg::REG_CTRL0_X];
      py[0] = ctrl_ff[bzs_pkg::REG_CTRL0_Y];
      px[1] = ctrl_ff[bzs_pkg::REG_CTRL1_X];
      py[1] = ctrl_ff[bzs_pkg::REG_CTRL1_Y];
      px[2] = ctrl_ff[bzs_pkg::REG_CTRL2_X];
      py[2] = ctrl_ff[bzs_pkg::REG_CTRL2_Y];
      px[3] = ctrl_ff[bzs_pkg::REG_CTRL3_X];
      py[3] = ctrl_ff[bzs_pkg::REG_CTRL3_Y];
   end

   bzs_seq #(.MAX_POINTS(MAX_POINTS)) u_seq (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .t_start     (req_t_start),
      .t_end       (req_t_end),
      .point_count (req_point_count),
      .busy        (busy),
      .pt          (pt)
   );

   bzs_eval u_eval (
      .clock     (clock),
      .reset     (reset),
      .pt        (pt),
      .px        (px),
      .py        (py),
      .out_valid (rsp_valid),
      .out_x     (rsp_point_x),
      .out_y     (rsp_point_y),
      .out_index (rsp_point_index),
      .out_last  (rsp_last)
   );

endmodule

>>> rtl/bzs_checker.sv
`timescale 1ns / 1ps
module bzs_checker (
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic [6:0] req_point_count,
   input logic       rsp_valid,
   input logic [5:0] rsp_point_index,
   input logic       rsp_last
);

   // reset empties the pipeline
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result strobed right after reset");

   // an empty request leaves the block idle
   a_empty_idle: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_point_count == 7'd0) |=> !busy)
      else $error("empty request made the block busy");

   // a real request makes the block busy
   a_req_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_point_count != 7'd0) |=> busy)
      else $error("accepted request did not raise busy");

   // points of a run come back to back in index order
   a_run_order: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |=>
         (rsp_valid && rsp_point_index == 6'($past(rsp_point_index) + 1'b1)))
      else $error("gap or misordered point inside a run");

endmodule

bind cubic_bezier_point_sampler_top bzs_checker u_bzs_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .req_point_count (req_point_count),
   .rsp_valid       (rsp_valid),
   .rsp_point_index (rsp_point_index),
   .rsp_last        (rsp_last)
);

>>> tb/sv/cubic_bezier_point_sampler_top_tb.sv
`timescale 1ns / 1ps
module cubic_bezier_point_sampler_top_tb;

   typedef struct {
      logic [31:0] x;
      logic [31:0] y;
      logic [5:0]  index;
      logic        last;
   } curve_point_type;

   // scoreboard: holds expected curve points and checks strobed results
   class point_scoreboard;
      logic signed [31:0] ctrl [bzs_pkg::NUM_REGS];
      curve_point_type    pending [$];
      int                 errors;

      function new();
         foreach (ctrl[k]) ctrl[k] = '0;
         errors = 0;
      endfunction

      // weighted sum of four coordinates, rounded half up, saturated
      function logic [31:0] blend_axis(int axis, logic [48:0] w [4]);
         logic signed [127:0] acc;
         logic signed [127:0] r;
         acc = 0;
         for (int k = 0; k < 4; k++)
            acc += $signed({{96{ctrl[2*k+axis][31]}}, ctrl[2*k+axis]}) *
                   $signed({79'd0, w[k]});
         r = (acc + (128'sd1 <<< 47)) >>> 48;
         if (r > 128'sd2147483647) return 32'h7fffffff;
         if (r < -128'sd2147483648) return 32'h80000000;
         return r[31:0];
      endfunction

      // expand one request into its sampled points
      function void note_request(logic [16:0] ts_in, logic [16:0] te_in, logic [6:0] cnt);
         longint ts, te, n, d, num, mag, q, t, s;
         logic [48:0] w [4];
         curve_point_type p;
         ts = ts_in > 65536 ? 65536 : ts_in;
         te = te_in > 65536 ? 65536 : te_in;
         n = cnt > 64 ? 64 : cnt;
         d = te - ts;
         for (longint i = 0; i < n; i++) begin
            t = ts;
            if (n > 1) begin
               num = d * i;
               mag = num < 0 ? -num : num;
               q = (mag + (n - 1) / 2) / (n - 1);
               t = ts + (num < 0 ? -q : q);
            end
            s = 65536 - t;
            w[0] = 49'(s * s * s);
            w[1] = 49'(3 * s * s * t);
            w[2] = 49'(3 * s * t * t);
            w[3] = 49'(t * t * t);
            p.x = blend_axis(0, w);
            p.y = blend_axis(1, w);
            p.index = i[5:0];
            p.last = (i == n - 1);
            pending.push_back(p);
         end
      endfunction

      task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
         if (errors < 40)
            $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
         errors++;
      endtask

      task check_point(curve_point_type got);
         curve_point_type want;
         if (pending.size() == 0) begin
            report_mismatch("point with none expected", 0, 0);
            return;
         end
         want = pending.pop_front();
         if (got.x !== want.x) report_mismatch("point_x", got.x, want.x);
         if (got.y !== want.y) report_mismatch("point_y", got.y, want.y);
         if (got.index !== want.index) report_mismatch("point_index", got.index, want.index);
         if (got.last !== want.last) report_mismatch("last", got.last, want.last);
      endtask
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        start = 0;
   logic        busy;
   logic [16:0] req_t_start = '0;
   logic [16:0] req_t_end = '0;
   logic [6:0]  req_point_count = '0;
   logic        rsp_valid;
   logic [31:0] rsp_point_x;
   logic [31:0] rsp_point_y;
   logic [5:0]  rsp_point_index;
   logic        rsp_last;
   logic        psel = 0;
   logic        penable = 0;
   logic        pwrite = 0;
   logic [4:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   point_scoreboard sb = new();
   longint cycles = 0;
   localparam longint CYCLE_LIMIT = 400000;

   cubic_bezier_point_sampler_top uut (.*);

   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   // check every strobed point; stop on timeout
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset && rsp_valid)
         sb.check_point('{rsp_point_x, rsp_point_y, rsp_point_index, rsp_last});
      if (cycles > CYCLE_LIMIT) begin
         $display("cubic_bezier_point_sampler_top_tb: errors");
         $finish;
      end
   end

   task write_ctrl(logic [2:0] idx, logic [31:0] val);
      @(negedge clock);
      psel <= 1; penable <= 0; pwrite <= 1;
      paddr <= {idx, 2'b00}; pwdata <= val;
      @(negedge clock);
      penable <= 1;
      do @(posedge clock); while (!pready);
      sb.ctrl[idx] = val;
      @(negedge clock);
      psel <= 0; penable <= 0; pwrite <= 0;
   endtask

   // drain outstanding points, then allow the tail latency
   task wait_idle();
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   // present a request at a falling edge and hold it until accepted
   task send_request(logic [16:0] ts, logic [16:0] te, logic [6:0] cnt);
      @(negedge clock);
      start <= 1;
      req_t_start <= ts; req_t_end <= te; req_point_count <= cnt;
      @(posedge clock);
      while (busy) @(posedge clock);
      sb.note_request(ts, te, cnt);
   endtask

   task drop_start();
      @(negedge clock);
      start <= 0;
   endtask

   function logic [31:0] rand_coord(int mode);
      case (mode)
         0: return 32'h7fffffff;
         1: return 32'h80000000;
         2: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
         default: return $urandom;
      endcase
   endfunction

   function logic [16:0] rand_t();
      case ($urandom_range(0, 7))
         0: return 17'd0;
         1: return 17'd65536;
         2: return 17'h1ffff;
         3: return 17'($urandom_range(65537, 131071));
         default: return 17'($urandom_range(0, 65536));
      endcase
   endfunction

   function logic [6:0] rand_count();
      case ($urandom_range(0, 9))
         0: return 7'd0;
         1: return 7'd1;
         2: return 7'($urandom_range(65, 127));
         3: return 7'd64;
         default: return 7'($urandom_range(2, 12));
      endcase
   endfunction

   initial begin
      int burst;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // directed: default control points, then a mixed curve
      send_request(17'd0, 17'd65536, 7'd5);
      drop_start();
      wait_idle();
      write_ctrl(bzs_pkg::REG_CTRL0_X, 32'h0000_0000);
      write_ctrl(bzs_pkg::REG_CTRL0_Y, 32'hffff_0000);
      write_ctrl(bzs_pkg::REG_CTRL1_X, 32'h0003_8000);
      write_ctrl(bzs_pkg::REG_CTRL1_Y, 32'h0010_0001);
      write_ctrl(bzs_pkg::REG_CTRL2_X, 32'hfff0_0000);
      write_ctrl(bzs_pkg::REG_CTRL2_Y, 32'h0002_4000);
      write_ctrl(bzs_pkg::REG_CTRL3_X, 32'h0100_0000);
      write_ctrl(bzs_pkg::REG_CTRL3_Y, 32'h8000_0000);
      send_request(17'd0, 17'd65536, 7'd0);
      send_request(17'd12345, 17'd0, 7'd1);
      send_request(17'd0, 17'd65536, 7'd64);
      send_request(17'd65536, 17'd0, 7'd127);
      send_request(17'h1ffff, 17'd100, 7'd7);
      send_request(17'd3, 17'h10001, 7'd2);
      send_request(17'd40000, 17'd40000, 7'd3);
      send_request(17'd1, 17'd2, 7'd65);
      send_request(17'h0aaaa, 17'h15555, 7'h55);
      send_request(17'h15555, 17'h0aaaa, 7'h2a);
      drop_start();
      wait_idle();

      // saturation extremes
      for (int k = 0; k < bzs_pkg::NUM_REGS; k++) write_ctrl(k[2:0], 32'h7fffffff);
      send_request(17'd0, 17'd65536, 7'd9);
      drop_start();
      wait_idle();
      for (int k = 0; k < bzs_pkg::NUM_REGS; k++) write_ctrl(k[2:0], 32'h80000000);
      send_request(17'd65536, 17'd0, 7'd9);
      drop_start();
      wait_idle();

      // random phases with new control points, bursts and gaps (phase 3 has no gaps)
      for (int ph = 0; ph < 8; ph++) begin
         for (int k = 0; k < bzs_pkg::NUM_REGS; k++)
            write_ctrl(k[2:0], rand_coord($urandom_range(0, 6)));
         for (int r = 0; r < 48; ) begin
            burst = $urandom_range(1, 8);
            for (int b = 0; b < burst && r < 48; b++, r++)
               send_request(rand_t(), rand_t(), rand_count());
            drop_start();
            if (ph != 3)
               repeat ($urandom_range(0, 25)) @(negedge clock);
         end
         wait_idle();
      end

      if (sb.errors == 0)
         $display("cubic_bezier_point_sampler_top_tb: clean");
      else
         $display("cubic_bezier_point_sampler_top_tb: errors");
      $finish;
   end
endmodule

>>> filelist.f
rtl/bzs_pkg.sv
rtl/bzs_div.sv
rtl/bzs_seq.sv
rtl/bzs_eval.sv
rtl/cubic_bezier_point_sampler_top.sv
rtl/bzs_checker.sv
tb/sv/cubic_bezier_point_sampler_top_tb.sv
